[design/cfcc_pkg.sv]
package cfcc_pkg;

  // receive buffer size; longest accepted payload is three bytes shorter
  localparam int BufferBytes = 256;
  localparam int MaxPayload  = BufferBytes - 3;

  // crc-8 generator polynomial and start value
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // number of payload bytes that form the sync counter
  localparam int SyncBytes = 8;

  // frame phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_LEN     = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_CRC     = 4'b1000
  } phase_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_CRC_ERR    = 2'd1,
    ST_LEN_OVER   = 2'd2,
    ST_SYNC_SHORT = 2'd3
  } status_t;

  // one finished frame report
  typedef struct packed {
    status_t     status;
    logic [7:0]  command;
    logic [7:0]  payload_length;
    logic [7:0]  computed_crc;
    logic [7:0]  received_crc;
    logic [63:0] sync_value;
    logic        sync_updated;
    logic        sync_ever_loaded;
  } result_t;

  // byte-wide crc-8 update, msb first, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[design/cfcc_frame_parser.sv]
module cfcc_frame_parser
  import cfcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] byte_value,
  input  logic       frame_start,
  input  logic [7:0] sync_opcode,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [7:0]  held_command, held_command_next;
  logic [7:0]  held_length, held_length_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [63:0] sync_shift, sync_shift_next;
  logic [63:0] sync_counter, sync_counter_next;
  logic        sync_flag, sync_flag_next;
  logic [7:0]  crc_upd;
  logic [8:0]  count_inc;

  assign crc_upd   = crc8_byte(running_crc, byte_value);
  assign count_inc = {1'b0, payload_count} + 9'd1;

  // frame state update and result on the crc byte
  always_comb begin
    phase_next         = phase;
    held_command_next  = held_command;
    held_length_next   = held_length;
    payload_count_next = payload_count;
    running_crc_next   = running_crc;
    sync_shift_next    = sync_shift;
    sync_counter_next  = sync_counter;
    sync_flag_next     = sync_flag;
    res_valid          = 1'b0;
    res.status         = ST_OK;
    res.sync_updated   = 1'b0;
    if (step) begin
      if (frame_start) begin
        held_command_next  = byte_value;
        held_length_next   = 8'd0;
        payload_count_next = 8'd0;
        sync_shift_next    = '0;
        running_crc_next   = crc8_byte(CRC_INIT, byte_value);
        phase_next         = PH_LEN;
      end else begin
        unique case (phase)
          PH_IDLE: begin
          end
          PH_LEN: begin
            held_length_next   = byte_value;
            running_crc_next   = crc_upd;
            payload_count_next = 8'd0;
            phase_next         = (byte_value == 8'd0) ? PH_CRC : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            running_crc_next = crc_upd;
            if (int'(payload_count) < SyncBytes) begin
              sync_shift_next = {sync_shift[55:0], byte_value};
            end
            payload_count_next = count_inc[7:0];
            if (count_inc >= {1'b0, held_length}) begin
              phase_next = PH_CRC;
            end
          end
          PH_CRC: begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            if (int'(held_length) > MaxPayload) begin
              res.status = ST_LEN_OVER;
            end else if (running_crc != byte_value) begin
              res.status = ST_CRC_ERR;
            end else if (held_command == sync_opcode) begin
              if (int'(held_length) >= SyncBytes) begin
                sync_counter_next = sync_shift;
                sync_flag_next    = 1'b1;
                res.sync_updated  = 1'b1;
              end else begin
                res.status = ST_SYNC_SHORT;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
    res.command          = held_command;
    res.payload_length   = held_length;
    res.computed_crc     = running_crc;
    res.received_crc     = byte_value;
    res.sync_value       = sync_counter_next;
    res.sync_ever_loaded = sync_flag_next;
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      held_command  <= 8'd0;
      held_length   <= 8'd0;
      payload_count <= 8'd0;
      running_crc   <= 8'd0;
      sync_shift    <= '0;
      sync_counter  <= '0;
      sync_flag     <= 1'b0;
    end else begin
      phase         <= phase_next;
      held_command  <= held_command_next;
      held_length   <= held_length_next;
      payload_count <= payload_count_next;
      running_crc   <= running_crc_next;
      sync_shift    <= sync_shift_next;
      sync_counter  <= sync_counter_next;
      sync_flag     <= sync_flag_next;
    end
  end

endmodule

[design/command_frame_crc_checker.sv]
// channel   direction  handshake              word
// in        input      in_valid / in_ready    byte_value, frame_start
// out       output     out_valid / out_ready  status .. sync_ever_loaded (one per frame)
// cfg       input      cfg_write              cfg_data (sync opcode)
//
// one byte per cycle unless a report is held back by out_ready: a byte taken is
// parsed from the input register, and a frame report is written to the output
// register when its crc byte is parsed.
// while a report waits with out_ready low nothing is parsed, and the input
// register holds at most one more byte before in_ready drops.
// rst is synchronous and clears the frame state, sync counter and sync flag.
module command_frame_crc_checker
  import cfcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  command,
  output logic [7:0]  payload_length,
  output logic [7:0]  computed_crc,
  output logic [7:0]  received_crc,
  output logic [63:0] sync_value,
  output logic        sync_updated,
  output logic        sync_ever_loaded
);

  logic [7:0] sync_opcode;
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_start;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    out_word;

  // sync opcode register
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_opcode <= 8'd0;
    end else if (cfg_write) begin
      sync_opcode <= cfg_data;
    end
  end

  // handshake: parse when a byte is held and the report slot is free or being read
  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte  <= byte_value;
      in_start <= frame_start;
    end
  end

  cfcc_frame_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .byte_value  (in_byte),
    .frame_start (in_start),
    .sync_opcode (sync_opcode),
    .res_valid   (res_valid),
    .res         (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_word <= res;
    end
  end

  assign status           = out_word.status;
  assign command          = out_word.command;
  assign payload_length   = out_word.payload_length;
  assign computed_crc     = out_word.computed_crc;
  assign received_crc     = out_word.received_crc;
  assign sync_value       = out_word.sync_value;
  assign sync_updated     = out_word.sync_updated;
  assign sync_ever_loaded = out_word.sync_ever_loaded;

endmodule
